// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/b64e_pkg.sv =====
`default_nettype none
package b64e_pkg;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] GPL_RESET    = 8'd18;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_item;

    // Work for one group of up to three input bytes: sextets first, then optional newlines.
    typedef struct packed {
        logic [3:0][5:0] sext;
        logic [2:0]      n_sext;
        logic            mid_nl;
        logic            end_nl;
    } t_job;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        c = 8'(v);
        priority if (v < 6'd26) begin
            return c + 8'd65;
        end else if (v < 6'd52) begin
            return c + 8'd71;
        end else if (v < 6'd62) begin
            return c - 8'd4;
        end else if (v == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/b64e_fifo.sv =====
`default_nettype none
module b64e_fifo (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  b64e_pkg::t_job     i_job,
    input  wire                i_pop,
    output logic               o_full,
    output logic               o_empty,
    output b64e_pkg::t_job     o_head
);

    b64e_pkg::t_job                 r_mem [b64e_pkg::Q_DEPTH];
    logic [b64e_pkg::Q_AW-1:0]      r_wr_ptr, n_wr_ptr;
    logic [b64e_pkg::Q_AW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [b64e_pkg::Q_CW-1:0]      r_count,  n_count;

    assign o_full  = (r_count == b64e_pkg::Q_CW'(b64e_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == b64e_pkg::Q_AW'(b64e_pkg::Q_DEPTH - 1)) ? '0
                     : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == b64e_pkg::Q_AW'(b64e_pkg::Q_DEPTH - 1)) ? '0
                     : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/b64e_front.sv =====
`default_nettype none
module b64e_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [7:0]            i_cfg_wdata,
    input  wire                  i_valid,
    input  b64e_pkg::t_in_item   i_in,
    input  wire                  i_q_full,
    output logic                 o_stall,
    output logic                 o_push,
    output b64e_pkg::t_job       o_job
);

    logic [7:0] r_gpl;
    logic [7:0] r_first,  n_first;
    logic [7:0] r_second, n_second;
    logic [1:0] r_pos,    n_pos;
    logic [7:0] r_cnt,    n_cnt;
    logic       r_seen,   n_seen;
    logic       accept;
    logic [7:0] b;
    logic       last;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign b       = i_in.data_byte;
    assign last    = i_in.last_byte;
    assign o_push  = accept && (last || (r_pos == 2'd2));

    always_comb begin
        o_job    = '0;
        n_first  = r_first;
        n_second = r_second;
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_seen   = r_seen;
        o_job.end_nl = last;
        if (r_pos == 2'd0) begin
            o_job.sext[0] = b[7:2];
            o_job.sext[1] = {b[1:0], 4'b0000};
            o_job.n_sext  = 3'd2;
            n_first       = b;
            n_pos         = 2'd1;
        end else if (r_pos == 2'd1) begin
            o_job.sext[0] = r_first[7:2];
            o_job.sext[1] = {r_first[1:0], b[7:4]};
            o_job.sext[2] = {b[3:0], 2'b00};
            o_job.n_sext  = 3'd3;
            n_second      = b;
            n_pos         = 2'd2;
        end else begin
            o_job.sext[0] = r_first[7:2];
            o_job.sext[1] = {r_first[1:0], r_second[7:4]};
            o_job.sext[2] = {r_second[3:0], b[7:6]};
            o_job.sext[3] = b[5:0];
            o_job.n_sext  = 3'd4;
            o_job.mid_nl  = r_seen && (r_cnt == 8'd0);
            n_seen        = 1'b1;
            n_cnt         = ({1'b0, r_cnt} + 9'd1 >= {1'b0, r_gpl}) ? 8'd0
                          : r_cnt + 8'd1;
            n_pos         = 2'd0;
            n_first       = 8'd0;
            n_second      = 8'd0;
        end
        if (last) begin
            n_first  = 8'd0;
            n_second = 8'd0;
            n_pos    = 2'd0;
            n_cnt    = 8'd0;
            n_seen   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpl    <= b64e_pkg::GPL_RESET;
            r_first  <= '0;
            r_second <= '0;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_seen   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gpl <= i_cfg_wdata;
            end
            if (accept) begin
                r_first  <= n_first;
                r_second <= n_second;
                r_pos    <= n_pos;
                r_cnt    <= n_cnt;
                r_seen   <= n_seen;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/b64e_back.sv =====
`default_nettype none
module b64e_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_q_empty,
    input  b64e_pkg::t_job       i_head,
    output logic                 o_pop,
    input  wire                  i_stall,
    output logic                 o_valid,
    output b64e_pkg::t_out_item  o_out
);

    logic [2:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_char, n_out_char;
    logic       r_out_last, n_out_last;
    logic       load_en;
    logic       emit;
    logic [2:0] total;
    logic       at_end;

    assign load_en = !r_out_valid || !i_stall;
    assign emit    = load_en && !i_q_empty;
    assign total   = i_head.n_sext + {2'b00, i_head.mid_nl} + {2'b00, i_head.end_nl};
    assign at_end  = (r_idx == total - 3'd1);
    assign o_pop   = emit && at_end;

    assign o_valid         = r_out_valid;
    assign o_out.out_char  = r_out_char;
    assign o_out.last_char = r_out_last;

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        if (load_en) begin
            n_out_valid = !i_q_empty;
        end
        if (emit) begin
            n_idx = at_end ? 3'd0 : r_idx + 3'd1;
            if (r_idx < i_head.n_sext) begin
                n_out_char = b64e_pkg::b64_char(i_head.sext[r_idx[1:0]]);
            end else begin
                n_out_char = b64e_pkg::NEWLINE_CHAR;
            end
            n_out_last = at_end && i_head.end_nl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

endmodule
`default_nettype wire

// ===== rtl/base64_line_encoder_core.sv =====
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------
// input    | in        | i_valid / o_stall    | i_in  : data_byte, last_byte
// output   | out       | o_valid / i_stall    | o_out : out_char, last_char
// config   | in        | i_cfg_we             | i_cfg_wdata : groups_per_line
//
// One output character per cycle while the queue holds a job and i_stall is
// low; each byte adds 0 to 6 characters, so a 3-byte group gives 4 to 6,
// all sent through the single character port of the back end.
// A two-entry job queue lets the front take bytes while the back drains.
// Synchronous active-low reset; groups_per_line resets to 18.
`default_nettype none
module base64_line_encoder_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [7:0]            i_cfg_wdata,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  b64e_pkg::t_in_item   i_in,
    output logic                 o_valid,
    input  wire                  i_stall,
    output b64e_pkg::t_out_item  o_out
);

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    b64e_pkg::t_job push_job;
    b64e_pkg::t_job head_job;

    b64e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_job       (push_job)
    );

    b64e_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    b64e_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (head_job),
        .o_pop     (pop),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

// ===== rtl/b64e_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module b64e_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_stall,
    input wire                 o_valid,
    input wire                 i_stall,
    input b64e_pkg::t_out_item o_out
);

    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "output dropped while stalled")
    `ASSERT_CLK_RST(a_out_stable, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_out), "stalled output changed")
    `ASSERT_CLK_RST(a_last_is_nl, i_clk, i_rst_n, o_valid && o_out.last_char |-> o_out.out_char == b64e_pkg::NEWLINE_CHAR, "last char is not a newline")
    `ASSERT_CLK(a_reset_idle, i_clk, !i_rst_n |=> !o_valid && !o_stall, "not idle after reset")

endmodule

bind base64_line_encoder_core b64e_checker u_b64e_checker (.*);
`default_nettype wire
